>>> hw/rtl/bnb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnb_pkg: shared types and codes
// Transaction payloads, opcodes and sequencer states for the naive Bayes block.
// ----------------------------------------------------------------------------
package bnb_pkg;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_TRAIN   = 2'd1;
	localparam logic [1:0] OP_PREDICT = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] yes_bits;
		logic [15:0] known_mask;
		logic        class_label;
	} bnb_in_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic       predicted_label;
		logic       count_saturated;
	} bnb_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TR_RD,
		S_TR_WR,
		S_PR_START,
		S_PR_FEAT,
		S_PR_LOAD,
		S_PR_NEXT,
		S_LG_E,
		S_LG_SH,
		S_LG_SQ,
		S_DONE
	} bnb_state_t;

	// What the log2 result is used for when it finishes.
	typedef enum logic [1:0] {
		P_NP2,
		P_N,
		P_FEAT
	} bnb_purpose_t;

endpackage

>>> hw/rtl/bernoulli_naive_bayes_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bernoulli_naive_bayes_classifier: two-class Bernoulli naive Bayes
// Clears, trains and predicts over up to sixteen binary features with add-one
// smoothing, using one shared iterative fixed-point log2 unit.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. Train walks every feature slot
// and does a read-modify-write of the yes-count memory for each known yes
// feature. Predict with both classes trained runs, per class, one log2
// evaluation each for n + 2, n and every known feature, loading each known
// feature's operand before its evaluation, then changes class. A predict
// with a class untrained goes straight to the output.
// The log2 unit does one 32x32 squaring per fraction bit. The
// input is not ready while an item is being worked; a finished result waits
// in an output register, so the next item may be accepted before it is taken.
// Reset and clear mark every yes count invalid (reads as zero) at once.
module bernoulli_naive_bayes_classifier
	import bnb_pkg::*;
#(
	parameter int NUM_FEATURES  = 16,
	parameter int COUNT_BITS    = 16,
	parameter int LOG_FRAC_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bnb_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output bnb_out_t out_data
);

	localparam int FEAT_USED = (NUM_FEATURES < 16) ? NUM_FEATURES : 16;
	localparam int FW        = $clog2(FEAT_USED + 1);
	localparam int DEPTH     = 2 * NUM_FEATURES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int XW        = COUNT_BITS + 1;          // holds n + 2
	localparam int EW        = $clog2(XW);              // exponent of x
	localparam int LW        = EW + LOG_FRAC_BITS;      // log2 result
	localparam int IW        = (LOG_FRAC_BITS > 1) ? $clog2(LOG_FRAC_BITS) : 1;
	localparam int SW        = LOG_FRAC_BITS + 16;      // signed score
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	bnb_state_t   state_q, state_d;
	bnb_purpose_t purp_q;
	bnb_in_t      cmd_q;
	logic         cls_q;
	logic [FW-1:0] feat_q;
	logic         pred_q, sat_q;

	logic [COUNT_BITS-1:0] cnt_q [2];
	logic [COUNT_BITS-1:0] n_q;
	logic [DEPTH-1:0]      valid_q;
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rd_q;
	logic                  rdv_q;

	// log2 unit
	logic [XW-1:0]            x_q;
	logic [EW-1:0]            e_q;
	logic [31:0]              m_q;
	logic [IW-1:0]            it_q;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [LW-1:0]            lnp2_q;

	logic signed [SW-1:0] s_q, s1_q;

	logic              out_valid_q;
	bnb_out_t          out_q;

	// control
	logic              accept, rd_en, wr_en, feat_end, feat_bit, log_last;
	logic [ADDR_W-1:0] addr;
	logic [3:0]        fidx;

	// datapath helpers
	logic [EW-1:0]            msb;
	logic [XW+30:0]           shifted;
	logic [63:0]              prod;
	logic [32:0]              sq;
	logic [LOG_FRAC_BITS-1:0] frac_nx;
	logic [LW-1:0]            lg;
	logic [COUNT_BITS-1:0]    y_raw, y_cl, ny, cnt_nx;
	logic [XW-1:0]            x_feat;

	assign accept   = in_valid && in_ready;
	assign fidx     = 4'(feat_q);
	assign feat_end = (feat_q == FW'(FEAT_USED));
	assign feat_bit = (state_q == S_TR_RD)
		? (cmd_q.yes_bits[fidx] && cmd_q.known_mask[fidx])
		: cmd_q.known_mask[fidx];
	assign log_last = (it_q == IW'(LOG_FRAC_BITS - 1));
	assign addr     = cls_q ? (ADDR_W'(NUM_FEATURES) + ADDR_W'(feat_q)) : ADDR_W'(feat_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_data.opcode == OP_TRAIN) begin
						state_d = S_TR_RD;
					end else if (in_data.opcode == OP_PREDICT && cnt_q[1] != '0
						&& cnt_q[0] != '0) begin
						state_d = S_PR_START;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_TR_RD: begin
				if (feat_end) begin
					state_d = S_DONE;
				end else if (feat_bit) begin
					state_d = S_TR_WR;
				end
			end
			S_TR_WR:    state_d = S_TR_RD;
			S_PR_START: state_d = S_LG_E;
			S_PR_FEAT: begin
				if (feat_end) begin
					state_d = S_PR_NEXT;
				end else if (feat_bit) begin
					state_d = S_PR_LOAD;
				end
			end
			S_PR_LOAD:  state_d = S_LG_E;
			S_PR_NEXT:  state_d = cls_q ? S_PR_START : S_DONE;
			S_LG_E:     state_d = S_LG_SH;
			S_LG_SH:    state_d = S_LG_SQ;
			S_LG_SQ: begin
				if (log_last) begin
					state_d = (purp_q == P_NP2) ? S_LG_E : S_PR_FEAT;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		rd_en    = ((state_q == S_TR_RD) || (state_q == S_PR_FEAT)) && !feat_end && feat_bit;
		wr_en    = (state_q == S_TR_WR);
	end

	// log2 datapath
	always_comb begin
		msb = '0;
		for (int i = 0; i < XW; i++) begin
			if (x_q[i]) begin
				msb = EW'(i);
			end
		end
	end

	assign shifted = {x_q, 31'b0} >> e_q;
	assign prod    = 64'(m_q) * 64'(m_q);
	assign sq      = prod[63:31];
	assign frac_nx = {frac_q[LOG_FRAC_BITS-2:0], sq[32]};
	assign lg      = {e_q, frac_nx};

	// Train and predict arithmetic on the counts.
	assign y_raw  = rdv_q ? rd_q : '0;
	assign y_cl   = (y_raw > n_q) ? n_q : y_raw;
	assign ny     = (y_raw == CNT_MAX) ? CNT_MAX : (y_raw + COUNT_BITS'(1));
	assign cnt_nx = (cnt_q[in_data.class_label] == CNT_MAX) ? CNT_MAX
		: (cnt_q[in_data.class_label] + COUNT_BITS'(1));
	assign x_feat = cmd_q.yes_bits[fidx] ? (XW'(y_cl) + XW'(1))
		: (XW'(n_q) + XW'(1) - XW'(y_cl));

	// Yes-count memory: one port, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= ny;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	// Control state and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && in_data.opcode == OP_CLEAR) begin
				valid_q  <= '0;
				cnt_q[0] <= '0;
				cnt_q[1] <= '0;
			end else if (accept && in_data.opcode == OP_TRAIN) begin
				cnt_q[in_data.class_label] <= cnt_nx;
			end
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			// Drop the result once taken; load the next one when it is done.
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and sequencer datapath.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdv_q <= valid_q[addr];
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q  <= in_data;
					cls_q  <= (in_data.opcode == OP_TRAIN) ? in_data.class_label : 1'b1;
					feat_q <= '0;
					pred_q <= (in_data.opcode == OP_PREDICT) && (cnt_q[1] != '0)
						&& (cnt_q[0] == '0);
					sat_q  <= (in_data.opcode == OP_TRAIN) && (cnt_nx == CNT_MAX);
				end
			end
			S_TR_RD: begin
				if (!feat_end && !feat_bit) begin
					feat_q <= feat_q + FW'(1);
				end
			end
			S_TR_WR: begin
				if (ny == CNT_MAX) begin
					sat_q <= 1'b1;
				end
				feat_q <= feat_q + FW'(1);
			end
			S_PR_START: begin
				n_q    <= cnt_q[cls_q];
				x_q    <= XW'(cnt_q[cls_q]) + XW'(2);
				purp_q <= P_NP2;
				feat_q <= '0;
			end
			S_PR_FEAT: begin
				if (!feat_end && !feat_bit) begin
					feat_q <= feat_q + FW'(1);
				end
			end
			S_PR_LOAD: begin
				x_q    <= x_feat;
				purp_q <= P_FEAT;
			end
			S_PR_NEXT: begin
				if (cls_q) begin
					s1_q  <= s_q;
					cls_q <= 1'b0;
				end else begin
					pred_q <= (s1_q > s_q);
				end
			end
			S_LG_E: begin
				e_q <= msb;
			end
			S_LG_SH: begin
				m_q    <= shifted[31:0];
				it_q   <= '0;
				frac_q <= '0;
			end
			S_LG_SQ: begin
				m_q    <= sq[32] ? sq[32:1] : sq[31:0];
				frac_q <= frac_nx;
				it_q   <= it_q + IW'(1);
				if (log_last) begin
					case (purp_q)
						P_NP2: begin
							lnp2_q <= lg;
							x_q    <= XW'(n_q);
							purp_q <= P_N;
						end
						P_N: begin
							s_q <= SW'(lg);
						end
						P_FEAT: begin
							s_q    <= s_q + SW'(lg) - SW'(lnp2_q);
							feat_q <= feat_q + FW'(1);
						end
						default: ;
					endcase
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_q.result_kind     <= cmd_q.opcode;
					out_q.predicted_label <= (cmd_q.opcode == OP_PREDICT) && pred_q;
					out_q.count_saturated <= (cmd_q.opcode == OP_TRAIN) && sat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/bnb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnb_checker: port-level checks
// Watches the classifier's ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
module bnb_checker
	import bnb_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input bnb_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input bnb_out_t out_data
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only predict transactions carry a label.
	a_label: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind != OP_PREDICT |-> !out_data.predicted_label)
		else $error("label on a non-predict result");

	// Only train transactions report saturation.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind != OP_TRAIN |-> !out_data.count_saturated)
		else $error("saturation on a non-train result");

	// Not ready in the cycle after taking an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

endmodule

bind bernoulli_naive_bayes_classifier bnb_checker u_bnb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Bernoulli naive Bayes classifier
// Sends clear, train and predict transactions, computes the expected result
// of each accepted transaction from a bit-accurate copy of the counters and
// the fixed-point log2 scoring, and compares every returned transaction in
// order. The sender and the receiver idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module tb_top;
	import bnb_pkg::*;

	localparam int NFEAT = 16;
	localparam int CNT_MAX = 65535;
	localparam int FRAC = 12;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 40000;

	// Scoreboard: mirrors the class and per-feature yes counters and holds
	// the results still owed by the block.
	class nb_scoreboard;
		int unsigned yes_cnt[2*NFEAT];
		int unsigned cls_cnt[2];
		bnb_out_t owed[$];
		int mismatches;

		function new();
			wipe();
			mismatches = 0;
		endfunction

		function void wipe();
			foreach (yes_cnt[i]) yes_cnt[i] = 0;
			cls_cnt[0] = 0;
			cls_cnt[1] = 0;
		endfunction

		// Fixed-point log2: top bit index plus fraction by repeated squaring.
		function longint log2_fx(longint unsigned x);
			int e;
			longint unsigned m;
			longint unsigned frac;
			e = 0;
			frac = 0;
			if (x == 0) return 0;
			while (e < 63 && (x >> (e + 1)) != 0) e++;
			if (e <= 31) m = x << (31 - e);
			else m = x >> (e - 31);
			for (int b = 0; b < FRAC; b++) begin
				m = (m * m) >> 31;
				frac = frac << 1;
				if (m >= 64'h1_0000_0000) begin
					frac = frac | 1;
					m = m >> 1;
				end
			end
			return (longint'(e) << FRAC) | longint'(frac);
		endfunction

		function longint class_score(int c, logic [15:0] yes, logic [15:0] known);
			longint unsigned n;
			longint unsigned y;
			longint s;
			longint k;
			n = cls_cnt[c];
			s = log2_fx(n);
			k = 0;
			for (int i = 0; i < NFEAT; i++) begin
				if (!known[i]) continue;
				y = yes_cnt[c*NFEAT + i];
				if (y > n) y = n;
				if (yes[i]) s += log2_fx(y + 1);
				else s += log2_fx(n + 1 - y);
				k++;
			end
			return s - k * log2_fx(n + 2);
		endfunction

		function void note_input(bnb_in_t t);
			bnb_out_t r;
			int lbl;
			r = '0;
			r.result_kind = t.opcode;
			lbl = t.class_label;
			case (t.opcode)
				OP_CLEAR: begin
					wipe();
				end
				OP_TRAIN: begin
					if (cls_cnt[lbl] < CNT_MAX) cls_cnt[lbl]++;
					if (cls_cnt[lbl] >= CNT_MAX) r.count_saturated = 1'b1;
					for (int i = 0; i < NFEAT; i++) begin
						if (!(t.yes_bits[i] && t.known_mask[i])) continue;
						if (yes_cnt[lbl*NFEAT + i] < CNT_MAX) yes_cnt[lbl*NFEAT + i]++;
						if (yes_cnt[lbl*NFEAT + i] >= CNT_MAX) r.count_saturated = 1'b1;
					end
				end
				OP_PREDICT: begin
					if (cls_cnt[1] == 0) r.predicted_label = 1'b0;
					else if (cls_cnt[0] == 0) r.predicted_label = 1'b1;
					else r.predicted_label = class_score(1, t.yes_bits, t.known_mask) >
						class_score(0, t.yes_bits, t.known_mask);
				end
				default: ;
			endcase
			owed = {owed, r};
		endfunction

		function void check_result(bnb_out_t got);
			bnb_out_t want;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = owed.pop_front();
			if (got.result_kind !== want.result_kind ||
					got.predicted_label !== want.predicted_label ||
					got.count_saturated !== want.count_saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	bnb_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	bnb_out_t out_data;

	nb_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	bernoulli_naive_bayes_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Receiver side: check each result transaction, pick the next stall,
	// and count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_data);
		out_ready <= ($urandom_range(99) >= stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Hold the transaction until accepted, then idle cycle by cycle at random.
	task automatic send(logic [1:0] op, logic [15:0] yes, logic [15:0] known, logic lbl);
		bnb_in_t t;
		t = '{opcode: op, yes_bits: yes, known_mask: known, class_label: lbl};
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_input(t);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Random item: mostly trains and predicts on class-dependent patterns.
	task automatic send_random();
		int pick;
		logic lbl;
		logic [15:0] proto;
		pick = $urandom_range(99);
		lbl = 1'($urandom_range(1));
		proto = lbl ? 16'hA5C3 : 16'h3C5A;
		proto = proto ^ 16'($urandom() & $urandom() & $urandom());
		if (pick < 2) send(OP_CLEAR, 16'($urandom()), 16'($urandom()),
			1'($urandom_range(1)));
		else if (pick < 4) send(OP_UNUSED, 16'($urandom()), 16'($urandom()),
			1'($urandom_range(1)));
		else if (pick < 52) send(OP_TRAIN, pick < 10 ? 16'($urandom()) : proto,
			$urandom_range(3) == 0 ? 16'($urandom()) : 16'hFFFF, lbl);
		else send(OP_PREDICT, pick < 60 ? 16'($urandom()) : proto,
			$urandom_range(3) == 0 ? 16'($urandom()) : 16'hFFFF, 1'($urandom_range(1)));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty model, one-sided model, ties, masks, unused opcode.
		send(OP_PREDICT, 16'hFFFF, 16'hFFFF, 1'b1);
		send(OP_TRAIN, 16'hFFFF, 16'h0000, 1'b1);
		send(OP_PREDICT, 16'h0000, 16'h0000, 1'b0);
		send(OP_TRAIN, 16'hFFFF, 16'hFFFF, 1'b0);
		send(OP_PREDICT, 16'hFFFF, 16'h0000, 1'b0);
		send(OP_TRAIN, 16'hFFFF, 16'hFFFF, 1'b1);
		send(OP_PREDICT, 16'hFFFF, 16'hFFFF, 1'b0);
		send(OP_TRAIN, 16'h00FF, 16'h0F0F, 1'b1);
		send(OP_TRAIN, 16'hFF00, 16'hFFFF, 1'b0);
		send(OP_PREDICT, 16'h00FF, 16'hFFFF, 1'b0);
		send(OP_PREDICT, 16'hFF00, 16'hFFFF, 1'b1);
		send(OP_PREDICT, 16'hFFFF, 16'h00FF, 1'b0);
		send(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
		send(OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
		send(OP_TRAIN, 16'h1234, 16'hFFFF, 1'b0);
		send(OP_PREDICT, 16'h1234, 16'hFFFF, 1'b0);
		send(OP_CLEAR, 16'h0000, 16'h0000, 1'b0);
		send(OP_PREDICT, 16'h5555, 16'hAAAA, 1'b0);

		// Random phases: none, sender idle, receiver stall, both.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 85 : (ph == 3) ? 28 : 0;
			stall_pct = (ph == 2) ? 85 : (ph == 3) ? 28 : 0;
			for (int n = 0; n < 350; n++) begin
				send_random();
				if (ph == 1 && n == 175) drain();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
